FILE: design/sspb_pkg.sv
// ----------------------------------------------------------------------------
// sspb_pkg
// Shared types and constants of the speed-scaled proximity brake.
// ----------------------------------------------------------------------------
package sspb_pkg;

  // Default width of the distance registers.
  localparam int DIST_BITS_DEF = 16;

  // Forward window: 0.61 rad in Q16, truncated.
  localparam logic signed [31:0] ANGLE_LIMIT_Q16 = 32'sd39976;
  localparam logic [23:0] SPEED_MAX = 24'hFF_FFFF;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [10:0] MM_PER_M = 11'd1000;

  // Reset values of the configuration registers.
  localparam logic [15:0] BRAKE_RST = 16'd250;
  localparam logic [15:0] RMIN_RST = 16'd0;
  localparam logic [15:0] RMAX_RST = 16'd12000;
  localparam logic [31:0] ASTART_RST = 32'hFFFC_DBC1;  // -205887
  localparam logic [31:0] ASTEP_RST = 32'd286;

  // Iteration counts, minus one, of the shared counter.
  localparam logic [5:0] SQRT_STEPS_M1 = 6'd33;
  localparam logic [5:0] DIV_STEPS_M1 = 6'd23;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_BRAKE  = 3'd0,
    REG_RMIN   = 3'd1,
    REG_RMAX   = 3'd2,
    REG_ASTART = 3'd3,
    REG_ASTEP  = 3'd4
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic sample_upd;
    logic sq_load;
    logic sq_step;
    logic axis_inc;
    logic rt_load;
    logic rt_step;
    logic dv_load;
    logic dv_step;
    logic pose_commit;
    logic ts_square;
    logic ts_compare;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_zero;
    logic last_axis;
    logic cnt_zero;
    logic pose_seen;
    logic div_sat;
  } stat_t;

endpackage

FILE: design/sspb_ctrl.sv
// ----------------------------------------------------------------------------
// sspb_ctrl
// Sequencer: steps one item through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module sspb_ctrl
  import sspb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_pose,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b0000_0000_0001,
    ST_SAMPLE  = 12'b0000_0000_0010,
    ST_SQ_LOAD = 12'b0000_0000_0100,
    ST_SQ_RUN  = 12'b0000_0000_1000,
    ST_RT_LOAD = 12'b0000_0001_0000,
    ST_RT_RUN  = 12'b0000_0010_0000,
    ST_DV_LOAD = 12'b0000_0100_0000,
    ST_DV_RUN  = 12'b0000_1000_0000,
    ST_COMMIT  = 12'b0001_0000_0000,
    ST_TS_SQ   = 12'b0010_0000_0000,
    ST_TS_CMP  = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (!in_pose) state_next = ST_SAMPLE;
          else if (stat.pose_seen) state_next = ST_SQ_LOAD;
          else state_next = ST_COMMIT;
        end
      end
      ST_SAMPLE: begin
        cmd.sample_upd = 1'b1;
        state_next = ST_TS_SQ;
      end
      ST_SQ_LOAD: begin
        cmd.sq_load = 1'b1;
        state_next = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        if (!stat.mul_zero) begin
          cmd.sq_step = 1'b1;
        end else if (stat.last_axis) begin
          state_next = ST_RT_LOAD;
        end else begin
          cmd.axis_inc = 1'b1;
          state_next = ST_SQ_LOAD;
        end
      end
      ST_RT_LOAD: begin
        cmd.rt_load = 1'b1;
        state_next = ST_RT_RUN;
      end
      ST_RT_RUN: begin
        cmd.rt_step = 1'b1;
        if (stat.cnt_zero) state_next = ST_DV_LOAD;
      end
      ST_DV_LOAD: begin
        cmd.dv_load = 1'b1;
        state_next = ST_DV_RUN;
      end
      ST_DV_RUN: begin
        if (stat.div_sat) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.dv_step = 1'b1;
          if (stat.cnt_zero) state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.pose_commit = 1'b1;
        state_next = ST_TS_SQ;
      end
      ST_TS_SQ: begin
        cmd.ts_square = 1'b1;
        state_next = ST_TS_CMP;
      end
      ST_TS_CMP: begin
        cmd.ts_compare = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/sspb_dp.sv
// ----------------------------------------------------------------------------
// sspb_dp
// Datapath: configuration, scan minimum, shift-add squarer, digit-by-digit
// square root, restoring divider, brake test and the result register.
// ----------------------------------------------------------------------------
module sspb_dp
  import sspb_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         cmd,
  output stat_t        stat,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data,
  input  logic [159:0] in_data,
  input  logic         in_last,
  output logic         o_close,
  output logic [15:0]  o_near,
  output logic [23:0]  o_speed,
  output logic         o_done
);

  localparam logic [DIST_BITS-1:0] DIST_NONE = {DIST_BITS{1'b1}};

  // Configuration.
  logic [15:0] brake, rmin, rmax;
  logic [31:0] astart, astep;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake <= BRAKE_RST;
      rmin <= RMIN_RST;
      rmax <= RMAX_RST;
      astart <= ASTART_RST;
      astep <= ASTEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BRAKE:  brake <= cfg_data[15:0];
        REG_RMIN:   rmin <= cfg_data[15:0];
        REG_RMAX:   rmax <= cfg_data[15:0];
        REG_ASTART: astart <= cfg_data;
        REG_ASTEP:  astep <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item registers.
  logic [15:0] rng;
  logic        last;
  logic [31:0] pos [3];
  logic [47:0] stamp;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rng <= in_data[15:0];
      pos[0] <= in_data[47:16];
      pos[1] <= in_data[79:48];
      pos[2] <= in_data[111:80];
      stamp <= in_data[159:112];
      last <= in_last;
    end
  end

  // Persistent state.
  logic [DIST_BITS-1:0] scan_min, nearest;
  logic [31:0] angle;
  logic [31:0] prev_pos [3];
  logic [47:0] prev_stamp;
  logic        pose_seen;
  logic [23:0] speed;
  logic        done;

  // Sample qualification.
  logic qualify, in_window;
  logic [DIST_BITS-1:0] min_new;
  assign in_window = ($signed(angle) <= ANGLE_LIMIT_Q16) &&
                     ($signed(angle) >= -ANGLE_LIMIT_Q16);
  assign qualify = (rmin < rng) && (rng < rmax) && in_window &&
                   (32'(rng) < 32'(scan_min));
  assign min_new = qualify ? DIST_BITS'(rng) : scan_min;

  // Work registers.
  logic [1:0]  axis;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [65:0] acc;
  logic [67:0] rad;
  logic [35:0] rem;
  logic [33:0] root;
  logic [5:0]  cnt;
  logic [53:0] dvn;
  logic [70:0] dsh;
  logic [23:0] quot;
  logic        sat;
  logic [49:0] fsq;
  logic        brake_hit;

  // Absolute difference of the current axis.
  logic [33:0] diff;
  logic [31:0] dabs;
  always_comb begin
    diff = 34'($signed(pos[axis])) - 34'($signed(prev_pos[axis]));
    dabs = diff[33] ? 32'(-diff) : diff[31:0];
  end

  // Square root step.
  logic [37:0] remsh, trial;
  assign remsh = {rem, rad[67:66]};
  assign trial = {2'b00, root, 2'b01};

  // Divider load and step.
  logic [47:0] dt;
  logic [53:0] num;
  logic        sat_now;
  assign dt = stamp - prev_stamp;
  assign num = 54'(root) * 54'(US_PER_S);
  assign sat_now = (dt == '0) || ({18'd0, num} >= {dt, 24'd0});

  // Brake test.
  logic [24:0] f;
  logic [65:0] prod;
  logic [65:0] lhs;
  assign f = 25'(speed) + 25'(MM_PER_M);
  assign prod = 66'(brake) * 66'(fsq);
  assign lhs = 66'(nearest) * 66'(US_PER_S);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_min <= DIST_NONE;
      nearest <= DIST_NONE;
      angle <= ASTART_RST;
      prev_pos[0] <= '0;
      prev_pos[1] <= '0;
      prev_pos[2] <= '0;
      prev_stamp <= '0;
      pose_seen <= 1'b0;
      speed <= '0;
    end else begin
      // Scan sample update; the last one commits the minimum.
      if (cmd.sample_upd) begin
        if (last) begin
          nearest <= min_new;
          scan_min <= DIST_NONE;
          angle <= astart;
        end else begin
          scan_min <= min_new;
          angle <= angle + astep;
        end
      end
      // Pose bookkeeping.
      if (cmd.pose_commit) begin
        prev_pos[0] <= pos[0];
        prev_pos[1] <= pos[1];
        prev_pos[2] <= pos[2];
        prev_stamp <= stamp;
        pose_seen <= 1'b1;
        if (pose_seen) speed <= quot;
      end
    end
  end

  // Arithmetic units.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      axis <= '0;
      acc <= '0;
      done <= 1'b0;
    end
    if (cmd.sample_upd) done <= last;
    if (cmd.axis_inc) axis <= axis + 2'd1;
    // Shift-add squarer, summed into acc.
    if (cmd.sq_load) begin
      mcand <= 64'(dabs);
      mplier <= dabs;
    end
    if (cmd.sq_step) begin
      if (mplier[0]) acc <= acc + 66'(mcand);
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
    end
    // Square root, two radicand bits per step.
    if (cmd.rt_load) begin
      rad <= {2'b00, acc};
      rem <= '0;
      root <= '0;
      cnt <= SQRT_STEPS_M1;
    end
    if (cmd.rt_step) begin
      rad <= rad << 2;
      cnt <= cnt - 6'd1;
      if (remsh >= trial) begin
        rem <= 36'(remsh - trial);
        root <= {root[32:0], 1'b1};
      end else begin
        rem <= remsh[35:0];
        root <= {root[32:0], 1'b0};
      end
    end
    // Restoring divider, one quotient bit per step.
    if (cmd.dv_load) begin
      dvn <= num;
      dsh <= {dt, 23'd0};
      sat <= sat_now;
      quot <= sat_now ? SPEED_MAX : '0;
      cnt <= DIV_STEPS_M1;
    end
    if (cmd.dv_step) begin
      cnt <= cnt - 6'd1;
      dsh <= dsh >> 1;
      if ({17'd0, dvn} >= dsh) begin
        dvn <= dvn - dsh[53:0];
        quot <= {quot[22:0], 1'b1};
      end else begin
        quot <= {quot[22:0], 1'b0};
      end
    end
    // Brake test in two registered steps; the flag waits for the result load.
    if (cmd.ts_square) fsq <= 50'(f) * 50'(f);
    if (cmd.ts_compare) brake_hit <= lhs < prod;
    if (cmd.out_load) begin
      o_close <= brake_hit;
      o_near <= 16'(32'(nearest));
      o_speed <= speed;
      o_done <= done;
    end
  end

  assign stat.mul_zero = (mplier == '0);
  assign stat.last_axis = (axis == 2'd2);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.pose_seen = pose_seen;
  assign stat.div_sat = sat;

endmodule

FILE: design/speed_scaled_proximity_brake.sv
// ----------------------------------------------------------------------------
// speed_scaled_proximity_brake
// Nearest forward obstacle from lidar samples, speed from odometry poses, and
// a brake flag when the obstacle is inside the speed-scaled distance.
//
//   channel | direction | handshake         | contents
//   s_*     | in        | s_tvalid/s_tready | sample or pose item
//   m_*     | out       | m_tvalid/m_tready | brake result item
//   cfg_*   | in        | cfg_we            | register write
//
// A range sample goes through the sample update and the two brake test steps.
// A pose runs three shift-add squares (one step per
// multiplier bit up to its highest set bit), 34 square root steps and 24 divider steps,
// the divider being skipped when it saturates; the first pose skips the squares, root and divider.
// One item is in work at a time; the result register lets the next item be
// accepted while a result waits for m_tready.
// Reset is synchronous and clears the configuration, the sequencer and the persistent state to their defaults.
// ----------------------------------------------------------------------------
module speed_scaled_proximity_brake
  import sspb_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // range_mm, pos_x_mm, pos_y_mm, pos_z_mm, stamp_us
  input  logic         s_tuser,  // pose item (else range sample)
  input  logic         s_tlast,  // last_sample
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // too_close, nearest_mm, speed_mm_s, zero fill
  output logic         m_tlast,  // scan_done
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic        o_close;
  logic [15:0] o_near;
  logic [23:0] o_speed;

  sspb_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_pose(s_tuser), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat(stat), .cmd(cmd)
  );

  sspb_dp #(.DIST_BITS(DIST_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_data(s_tdata), .in_last(s_tlast),
    .o_close(o_close), .o_near(o_near), .o_speed(o_speed), .o_done(m_tlast)
  );

  assign m_tdata = {7'd0, o_speed, o_near, o_close};

`ifndef SYNTHESIS
  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("item accepted while busy");

  // Loading the result register always presents a result.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid) else $error("result load lost");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_tvalid || m_tready) else $error("result overwritten");
`endif

endmodule
